// ----- rtl/csieve_pkg.sv -----
// Package for the Collatz residue sieve: field widths, the configuration word
// type and helper functions for depth clamping, residue masking and step bounds.
// No dependencies.
package csieve_pkg;

    localparam int RESIDUE_W     = 30;
    localparam int DEPTH_W       = 6;
    localparam int MIN_DEPTH     = 2;
    localparam int RESET_DEPTH   = 18;
    localparam int MAX_DEPTH_DEF = 32;

    typedef struct packed {
        logic [DEPTH_W-1:0]   depth;
        logic [RESIDUE_W-1:0] mask;
    } cfg_t;

    function automatic logic [DEPTH_W-1:0] clamp_depth(
        input logic [DEPTH_W-1:0] raw,
        input int                 max_depth
    );
        logic [DEPTH_W-1:0] d;
        d = raw;
        if (d < DEPTH_W'(MIN_DEPTH))
            d = DEPTH_W'(MIN_DEPTH);
        else if (d > DEPTH_W'(max_depth))
            d = DEPTH_W'(max_depth);
        return d;
    endfunction

    function automatic logic [RESIDUE_W-1:0] depth_mask(input logic [DEPTH_W-1:0] depth);
        logic [RESIDUE_W-1:0] m;
        for (int i = 0; i < RESIDUE_W; i++)
            m[i] = ((int'(depth) - MIN_DEPTH) > i);
        return m;
    endfunction

    // least t with 3^t >= 2^k, evaluated at elaboration
    function automatic int bound_for(input int k);
        longint unsigned p2;
        longint unsigned p3;
        int              t;
        p2 = 1;
        p3 = 1;
        t  = 0;
        for (int i = 0; i < k; i++)
            p2 = p2 << 1;
        for (int i = 0; i < 64; i++)
            if (p3 < p2)
            begin
                p3 = p3 * 3;
                t  = t + 1;
            end
        return t;
    endfunction

endpackage

// ----- rtl/collatz_residue_sieve.sv -----
// Collatz residue sieve top level: configuration register and a chain of
// MAX_DEPTH map-step stages. Depends on csieve_pkg, csieve_cfg, csieve_step.
//
// Usage:
//   Input channel in_valid/in_ready carries one residue word. Output channel
//   out_valid/out_ready returns residue_echo (the residue masked to its low
//   L-2 bits) and survives (1 when the odd-step count met the 3^q >= 2^k
//   bound after every step k up to L).
//   The configuration channel cfg_valid/cfg_ready writes sieve_depth (L);
//   it is always ready; the user must ensure it is written only while the
//   pipeline is empty, as the block itself does not enforce this. Stages
//   beyond L pass the word through unchanged in outcome. Throughput is one
//   word per cycle unless stalled. Each stage has its own valid bit and
//   ready; a stall on out_ready holds the last stage and back-pressure moves
//   upstream only as far as the first empty stage, so bubbles are absorbed.
//   Reset empties the pipeline and sets the depth to 18.
module collatz_residue_sieve
    import csieve_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DEPTH_W-1:0]   sieve_depth,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RESIDUE_W-1:0] residue,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RESIDUE_W-1:0] residue_echo,
    output logic                 survives
);

    localparam int W  = MAX_DEPTH;
    localparam int QW = $clog2(MAX_DEPTH+1);

    cfg_t                 cfg;
    logic                 s_valid [0:MAX_DEPTH];
    logic                 s_ready [0:MAX_DEPTH];
    logic [W-1:0]         s_x     [0:MAX_DEPTH];
    logic [QW-1:0]        s_q     [0:MAX_DEPTH];
    logic                 s_ok    [0:MAX_DEPTH];
    logic [RESIDUE_W-1:0] s_res   [0:MAX_DEPTH];
    logic [RESIDUE_W-1:0] res_masked;

    csieve_cfg #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .sieve_depth (sieve_depth),
        .cfg         (cfg)
    );

    // form x = 4r+3 from the masked residue
    assign res_masked = residue & cfg.mask;
    assign s_valid[0] = in_valid;
    assign in_ready   = s_ready[0];
    assign s_x[0]     = W'({res_masked, 2'b11});
    assign s_q[0]     = '0;
    assign s_ok[0]    = 1'b1;
    assign s_res[0]   = res_masked;

    for (genvar k = 1; k <= MAX_DEPTH; k++)
    begin : g_step
        csieve_step #(
            .MAX_DEPTH (MAX_DEPTH),
            .STEP      (k)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .up_valid (s_valid[k-1]),
            .up_ready (s_ready[k-1]),
            .up_x     (s_x[k-1]),
            .up_q     (s_q[k-1]),
            .up_ok    (s_ok[k-1]),
            .up_res   (s_res[k-1]),
            .dn_valid (s_valid[k]),
            .dn_ready (s_ready[k]),
            .dn_x     (s_x[k]),
            .dn_q     (s_q[k]),
            .dn_ok    (s_ok[k]),
            .dn_res   (s_res[k])
        );
    end

    assign s_ready[MAX_DEPTH] = out_ready;
    assign out_valid          = s_valid[MAX_DEPTH];
    assign residue_echo       = s_res[MAX_DEPTH];
    assign survives           = s_ok[MAX_DEPTH];

endmodule

// ----- rtl/csieve_cfg.sv -----
// Depth configuration register: clamps the written depth and precomputes
// the residue mask. Depends on csieve_pkg.
module csieve_cfg
    import csieve_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DEPTH_W-1:0] sieve_depth,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            cfg_next.depth = clamp_depth(sieve_depth, MAX_DEPTH);
            cfg_next.mask  = depth_mask(cfg_next.depth);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth <= clamp_depth(DEPTH_W'(RESET_DEPTH), MAX_DEPTH);
            cfg_reg.mask  <= depth_mask(clamp_depth(DEPTH_W'(RESET_DEPTH), MAX_DEPTH));
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

// ----- rtl/csieve_step.sv -----
// One pipeline stage: a single shortcut-map step with its odd-step bound check,
// registered behind a valid/ready slot. Depends on csieve_pkg.
module csieve_step
    import csieve_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int STEP      = 1
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfg_t                               cfg,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic [MAX_DEPTH-1:0]               up_x,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]     up_q,
    input  logic                               up_ok,
    input  logic [RESIDUE_W-1:0]               up_res,
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output logic [MAX_DEPTH-1:0]               dn_x,
    output logic [$clog2(MAX_DEPTH+1)-1:0]     dn_q,
    output logic                               dn_ok,
    output logic [RESIDUE_W-1:0]               dn_res
);

    localparam int W     = MAX_DEPTH;
    localparam int QW    = $clog2(MAX_DEPTH+1);
    localparam int BOUND = bound_for(STEP);

    logic          valid_reg;
    logic          valid_next;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  x_next;
    logic [QW-1:0] q_reg;
    logic [QW-1:0] q_next;
    logic          ok_reg;
    logic          ok_next;
    logic [RESIDUE_W-1:0] res_reg;
    logic [W-1:0]  x3;
    logic          odd;
    logic          active;

    // hold while a word waits downstream
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        odd     = up_x[0];
        x3      = up_x + {up_x[W-2:0], 1'b0} + W'(1);
        x_next  = odd ? {1'b0, x3[W-1:1]} : {1'b0, up_x[W-1:1]};
        q_next  = up_q + QW'(odd);
        active  = (cfg.depth >= DEPTH_W'(STEP));
        ok_next = up_ok && (!active || (q_next >= QW'(BOUND)));
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg   <= x_next;
            q_reg   <= q_next;
            ok_reg  <= ok_next;
            res_reg <= up_res;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_q     = q_reg;
    assign dn_ok    = ok_reg;
    assign dn_res   = res_reg;

endmodule

// ----- test/csieve_checker.sv -----
// Scoreboard for the Collatz residue sieve: tracks sieve_depth writes, predicts
// each accepted residue word and compares every result word in order.
// Depends on csieve_pkg.
module csieve_checker
    import csieve_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [DEPTH_W-1:0]   sieve_depth,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [RESIDUE_W-1:0] residue,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [RESIDUE_W-1:0] residue_echo,
    input  logic                 survives,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic [RESIDUE_W-1:0] echo;
        logic                 survives;
    } sieve_word_t;

    sieve_word_t        expected_words[$];
    logic [DEPTH_W-1:0] depth_reg;
    int                 err_count;

    function automatic sieve_word_t sieve_outcome(
        input logic [DEPTH_W-1:0]   raw_depth,
        input logic [RESIDUE_W-1:0] r
    );
        int              steps;
        int              q;
        int              bound;
        longint unsigned kept;
        longint unsigned x;
        longint unsigned pow2;
        longint unsigned pow3;
        sieve_word_t     w;
        steps = int'(raw_depth);
        if (steps < MIN_DEPTH)
            steps = MIN_DEPTH;
        if (steps > MAX_DEPTH_DEF)
            steps = MAX_DEPTH_DEF;
        kept  = longint'(r) & ((64'd1 << (steps - MIN_DEPTH)) - 64'd1);
        x     = 4 * kept + 3;
        pow2  = 1;
        pow3  = 1;
        bound = 0;
        q     = 0;
        w.survives = 1'b1;
        for (int k = 1; k <= steps; k++)
        begin
            if ((x & 64'd1) != 0)
            begin
                q = q + 1;
                x = (3 * x + 1) >> 1;
            end
            else
                x = x >> 1;
            pow2 = pow2 << 1;
            while (pow3 < pow2)
            begin
                pow3  = pow3 * 3;
                bound = bound + 1;
            end
            if (q < bound)
            begin
                w.survives = 1'b0;
                break;
            end
        end
        w.echo = kept[RESIDUE_W-1:0];
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        sieve_word_t got;
        sieve_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            depth_reg   <= DEPTH_W'(RESET_DEPTH);
            err_count    = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.echo     = residue_echo;
                got.survives = survives;
                if (expected_words.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected word: residue_echo %h survives %b",
                                 got.echo, got.survives);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: expected echo %h surv %b, got echo %h surv %b",
                                     want.echo, want.survives, got.echo, got.survives);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_words.push_back(sieve_outcome(depth_reg, residue));
            if (cfg_valid && cfg_ready)
                depth_reg <= sieve_depth;
            mismatches  <= err_count;
            outstanding <= expected_words.size();
        end
    end

endmodule

// ----- test/collatz_residue_sieve_tb.sv -----
// Stimulus and verdict for the Collatz residue sieve: sweeps sieve_depth across
// its range, sends corner and random residue words with random gaps and stalls.
// Depends on csieve_pkg, collatz_residue_sieve and csieve_checker.
module collatz_residue_sieve_tb;
    import csieve_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int PHASES     = 12;
    localparam int PER_PHASE  = 94;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [DEPTH_W-1:0]   sieve_depth;
    logic                 in_valid;
    logic                 in_ready;
    logic [RESIDUE_W-1:0] residue;
    logic                 out_valid;
    logic                 out_ready;
    logic [RESIDUE_W-1:0] residue_echo;
    logic                 survives;
    int                   mismatches;
    int                   outstanding;

    bit                   tx_calm;
    bit                   rx_calm;
    int                   idle_cycles;
    logic [RESIDUE_W-1:0] corner_words[$];
    int                   depth_plan[$];

    collatz_residue_sieve dut (.*);
    csieve_checker        scoreboard (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [RESIDUE_W-1:0] pick_residue();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return RESIDUE_W'($urandom);
        else if (roll < 80)
            return RESIDUE_W'($urandom_range(0, 255));
        else if (roll < 90)
            return ~RESIDUE_W'($urandom_range(0, 255));
        return RESIDUE_W'($urandom) >> $urandom_range(0, RESIDUE_W - 1);
    endfunction

    task automatic send_word(input logic [RESIDUE_W-1:0] r);
        in_valid <= 1'b1;
        residue  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic maybe_idle();
        int n;
        if (!tx_calm && $urandom_range(0, 99) < 30)
        begin
            n = gap_len();
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_depth(input int d);
        cfg_valid   <= 1'b1;
        sieve_depth <= DEPTH_W'(d);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold out_ready low for random stretches unless the phase is calm
    initial
    begin : sink
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else if (!rx_calm && $urandom_range(0, 99) < 25)
            begin
                hold = gap_len() - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int d;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        sieve_depth = '0;
        in_valid    = 1'b0;
        residue     = '0;
        tx_calm     = 1'b1;
        rx_calm     = 1'b1;
        corner_words = '{30'h0, 30'h3FFFFFFF, 30'h1, 30'h2, 30'h3, 30'h4, 30'h7, 30'h8,
                         30'hB, 30'h1B, 30'h1F, 30'h2AAAAAAA, 30'h15555555, 30'h20000000,
                         30'h8000, 30'hFFFF, 30'h3FFF0000, 30'hFF, 30'h1FFFF, 30'h10000};
        depth_plan = '{2, 0, 63, 32, 1, 33, 3, 31, 17};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset depth first, every corner word back to back
        foreach (corner_words[i])
            send_word(corner_words[i]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            d = (p < depth_plan.size()) ? depth_plan[p] : $urandom_range(0, 63);
            write_depth(d);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            send_word('0);
            send_word('1);
            for (int i = 0; i < PER_PHASE; i++)
            begin
                send_word(pick_residue());
                maybe_idle();
                if (p == 4 && i == PER_PHASE / 2)
                    drain();
            end
            drain();
        end

        rx_calm = 1'b0;
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
